@@ sv/tabt_pkg.sv @@
`timescale 1ns / 1ps

package tabt_pkg;

  // default number of table entries
  localparam int unsigned TABLE_DEPTH_DEF = 16;

  // block length unit
  localparam logic [15:0] MS_PER_MIN = 16'd60000;

  typedef enum logic [1:0] {
    MODE_QUERY  = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  // one table entry as stored in memory
  typedef struct packed {
    logic [15:0] addr;
    logic [47:0] start_ms;
    logic [15:0] minutes;
  } entry_t;

  // controls from the sequencer to the entry store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic kill;
    logic clear_all;
  } store_ctl_t;

endpackage

@@ sv/tabt_store.sv @@
`timescale 1ns / 1ps

module tabt_store
  import tabt_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  store_ctl_t      ctl_i,
  input  logic [IdxW-1:0] rd_idx_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  entry_t          wr_entry_i,
  input  logic [IdxW-1:0] kill_idx_i,
  output entry_t          rd_entry_o
);

  entry_t           mem_q [DEPTH];
  entry_t           rd_data_q;
  logic [DEPTH-1:0] live_q;    // address field holds a value
  logic [DEPTH-1:0] wr_q;      // entry written since reset
  logic             rd_live_q;
  logic             rd_wr_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_idx_i] <= wr_entry_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= '0;
      wr_q      <= '0;
      rd_live_q <= 1'b0;
      rd_wr_q   <= 1'b0;
    end else begin
      if (ctl_i.rd_en) begin
        rd_live_q <= live_q[rd_idx_i];
        rd_wr_q   <= wr_q[rd_idx_i];
      end
      if (ctl_i.clear_all) begin
        live_q <= '0;
      end else if (ctl_i.kill) begin
        live_q[kill_idx_i] <= 1'b0;
      end else if (ctl_i.wr_en) begin
        live_q[wr_idx_i] <= 1'b1;
      end
      if (ctl_i.wr_en) begin
        wr_q[wr_idx_i] <= 1'b1;
      end
    end
  end

  // unwritten or freed fields read as zero
  always_comb begin
    rd_entry_o.addr     = rd_live_q ? rd_data_q.addr : '0;
    rd_entry_o.start_ms = rd_wr_q ? rd_data_q.start_ms : '0;
    rd_entry_o.minutes  = rd_wr_q ? rd_data_q.minutes : '0;
  end

endmodule

@@ sv/tabt_check.sv @@
`timescale 1ns / 1ps

module tabt_check
  import tabt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_v_i,
  input  logic        in_last_i,
  input  logic        match_i,
  input  entry_t      entry_i,
  input  logic [47:0] now_ms_i,
  output logic        blk_o,
  output logic        done_o
);

  logic        a_v_q;
  logic        a_last_q;
  logic        a_match_q;
  logic [47:0] a_start_q;
  logic [31:0] a_prod_q;
  logic [48:0] until_ms;
  logic        blk_q;
  logic        done_q;

  always_ff @(posedge clk_i) begin
    a_match_q <= match_i;
    a_start_q <= entry_i.start_ms;
    a_prod_q  <= 32'(entry_i.minutes) * 32'(MS_PER_MIN);
  end

  // full-width end of block, cannot wrap
  assign until_ms = {1'b0, a_start_q} + {17'd0, a_prod_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q    <= 1'b0;
      a_last_q <= 1'b0;
      blk_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      a_v_q    <= in_v_i;
      a_last_q <= in_v_i && in_last_i;
      blk_q    <= a_v_q && a_match_q && ({1'b0, now_ms_i} < until_ms);
      done_q   <= a_v_q && a_last_q;
    end
  end

  assign blk_o  = blk_q;
  assign done_o = done_q;

endmodule

@@ sv/timed_address_block_table.sv @@
`timescale 1ns / 1ps
// query, add and remove walk every entry through the store read register and the
// check stages, then commit; clear goes straight to commit; an output stall holds
// commit; one transaction at a time, the input stalls from accept until the result
// is loaded, since the walk uses the single read port of the entry memory
// reset: asynchronous, active low; per-entry flags clear at once so the table reads as
// all zero right after reset, no clearing pass

module timed_address_block_table
  import tabt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] device_address_i,
  input  logic [15:0] block_minutes_i,
  input  logic [47:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        relay_allowed_o,
  output logic        status_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  state_e state_q, state_d;

  // transaction fields held for the walk
  mode_e       mode_q;
  logic [15:0] addr_q;
  logic [15:0] mins_q;
  logic [47:0] now_q;

  // read issue and read-data stage
  logic [IdxW-1:0] rd_idx_q;
  logic            s1_v_q;
  logic            s1_last_q;
  logic [IdxW-1:0] s1_idx_q;

  // add target search and query verdict
  logic            found_v_q;
  logic [IdxW-1:0] found_idx_q;
  logic            free_v_q;
  logic [IdxW-1:0] free_idx_q;
  logic            blocked_q;

  logic out_valid_q;
  logic allowed_q;
  logic status_q;

  store_ctl_t ctl;
  entry_t     rd_entry;
  entry_t     wr_entry;
  logic       match;
  logic       chk_blk;
  logic       chk_done;
  logic       in_acc;
  logic       out_free;
  logic       add_full;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign match    = s1_v_q && (rd_entry.addr == addr_q);
  assign add_full = !found_v_q && !free_v_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (mode_e'(mode_i) == MODE_CLEAR) ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_idx_q == LastIdx) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (chk_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.rd_en     = (state_q == S_SCAN);
    ctl.kill      = match && (mode_q == MODE_REMOVE);
    ctl.clear_all = (state_q == S_COMMIT) && (mode_q == MODE_CLEAR);
    // add writes once, together with the result, unless the table is full
    ctl.wr_en     = (state_q == S_COMMIT) && out_free && (mode_q == MODE_ADD) && !add_full;
    wr_entry.addr     = addr_q;
    wr_entry.start_ms = now_q;
    wr_entry.minutes  = mins_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= mode_e'(mode_i);
      addr_q <= device_address_i;
      mins_q <= block_minutes_i;
      now_q  <= now_ms_i;
    end
    s1_idx_q <= rd_idx_q;
    if (state_q == S_COMMIT && out_free) begin
      allowed_q <= (mode_q != MODE_QUERY) || !blocked_q;
      status_q  <= (mode_q == MODE_ADD) && add_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_idx_q    <= '0;
      s1_v_q      <= 1'b0;
      s1_last_q   <= 1'b0;
      found_v_q   <= 1'b0;
      found_idx_q <= '0;
      free_v_q    <= 1'b0;
      free_idx_q  <= '0;
      blocked_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      s1_v_q    <= ctl.rd_en;
      s1_last_q <= ctl.rd_en && (rd_idx_q == LastIdx);

      if (in_acc) begin
        rd_idx_q  <= '0;
        found_v_q <= 1'b0;
        free_v_q  <= 1'b0;
        blocked_q <= 1'b0;
      end else begin
        if (ctl.rd_en) begin
          rd_idx_q <= rd_idx_q + IdxW'(1);
        end
        // last matching entry wins, first free entry wins
        if (match) begin
          found_v_q   <= 1'b1;
          found_idx_q <= s1_idx_q;
        end
        if (s1_v_q && rd_entry.addr == '0 && !free_v_q) begin
          free_v_q   <= 1'b1;
          free_idx_q <= s1_idx_q;
        end
        if (chk_blk) begin
          blocked_q <= 1'b1;
        end
      end

      if (state_q == S_COMMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  tabt_store #(
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .rd_idx_i   (rd_idx_q),
    .wr_idx_i   (found_v_q ? found_idx_q : free_idx_q),
    .wr_entry_i (wr_entry),
    .kill_idx_i (s1_idx_q),
    .rd_entry_o (rd_entry)
  );

  // expiry compare, two stages behind the read data
  tabt_check u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_v_i    (s1_v_q),
    .in_last_i (s1_last_q),
    .match_i   (match),
    .entry_i   (rd_entry),
    .now_ms_i  (now_q),
    .blk_o     (chk_blk),
    .done_o    (chk_done)
  );

  // busy from accept until the result is loaded
  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign relay_allowed_o = allowed_q;
  assign status_o        = status_q;

endmodule

@@ sv/tabt_checker.sv @@
`timescale 1ns / 1ps

module tabt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        relay_allowed_o,
  input logic        status_o
);

  // one transaction at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a transaction is in flight");

  // a result appears only at the end of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a transaction in flight");

  // table full only comes from add, which always reports allowed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> relay_allowed_o)
    else $error("table full reported with relay blocked");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(relay_allowed_o)
      && $stable(status_o))
    else $error("stalled result changed");

endmodule

bind timed_address_block_table tabt_checker u_tabt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .relay_allowed_o (relay_allowed_o),
  .status_o        (status_o)
);
